// ----- hdl/stereo_db_gain_fade_top_macros.svh -----
// Assertion macros used by the checker file.
`ifndef STEREO_DB_GAIN_FADE_TOP_MACROS_SVH
`define STEREO_DB_GAIN_FADE_TOP_MACROS_SVH

// Checked only while out of reset.
`define SDGF_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define SDGF_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/sdgf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sdgf_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int LEVEL_BITS    = 24;
  localparam int STEP_BITS     = 23;
  localparam int SUM_BITS      = 26;
  localparam int SPAN_BITS     = 23;
  localparam int GAIN_BITS     = 24;
  localparam int GAIN_FRAC     = 23;
  localparam int FRAC_BITS     = 24;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 24;

  // Level limits in 2^-16 dB units: -120 dB .. 0 dB.
  localparam int LEVEL_MIN_INT = -7864320;
  localparam int LEVEL_SPAN    = 7864320;
  localparam int HALF_SPAN     = 3932160;

  // LEVEL_SPAN = 15 << SPAN_SHIFT; the divide by 15 is a reciprocal multiply,
  // exact for quotient inputs below 2^24 / 14.
  localparam int SPAN_SHIFT    = 19;
  localparam int RECIP_BITS    = 21;
  localparam logic [RECIP_BITS-1:0] RECIP_15 = 21'd1118482;
  localparam int RECIP_SHIFT   = 24;

  localparam logic [STEP_BITS-1:0] STEP_RESET = 23'd16384;

  // Sample delay so the lanes meet the gain read out of the ROM.
  localparam int SAMPLE_DELAY  = 4;
  localparam int QUEUE_DEPTH   = 8;

  // 6 * log2(10) in Q24, full-scale attenuation exponent.
  localparam logic [63:0] ATTEN_FULL_Q24 = 64'd334396231;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FADE_DOWN   = 2'd0,
    REG_START_LEVEL = 2'd1,
    REG_STEP_SIZE   = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic                          end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          last;
  } out_item_t;

  typedef struct packed {
    logic                     we;
    logic [CFG_IDX_BITS-1:0]  idx;
    logic [CFG_DATA_BITS-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

  typedef logic [FRAC_BITS:0][63:0] root_tab_t;

  // Elaboration-time helpers for the gain ROM contents.
  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    int k;
    v = val;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (k = 0; k < 32; k++) begin
      if (b > v) b = b >> 2;
    end
    for (k = 0; k < 32; k++) begin
      if (b != 64'd0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // Q32 factors 2^-(2^-k), by repeated square roots.
  function automatic root_tab_t root_table();
    root_tab_t t;
    int k;
    t = '0;
    t[1] = isqrt64(64'h8000_0000_0000_0000);
    for (k = 2; k <= FRAC_BITS; k++) begin
      t[k] = isqrt64(t[k-1] << 32);
    end
    return t;
  endfunction

  function automatic logic [GAIN_BITS-1:0] gain_from_atten(input logic [63:0] a,
                                                           input root_tab_t roots);
    logic [63:0] g;
    logic [63:0] n;
    int k;
    n = a >> FRAC_BITS;
    g = 64'd1 << 32;
    for (k = 1; k <= FRAC_BITS; k++) begin
      if (a[FRAC_BITS-k]) g = (g * roots[k] + (64'd1 << 31)) >> 32;
    end
    g = (g + (64'd1 << (n + 64'd8))) >> (n + 64'd9);
    return g[GAIN_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/sdgf_gain_rom.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sdgf_gain_rom
  import sdgf_pkg::*;
#(
  parameter int GAIN_TABLE_DEPTH = 4096
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic [$clog2(GAIN_TABLE_DEPTH)-1:0] idx_i,
  input  wire stage_ctl_t                          ctl_i,
  output logic [GAIN_BITS-1:0]                     gain_o,
  output stage_ctl_t                               ctl_o
);

  localparam root_tab_t   ROOTS = root_table();
  localparam logic [63:0] D1    = 64'(GAIN_TABLE_DEPTH - 1);

  logic [GAIN_BITS-1:0] rom_w [GAIN_TABLE_DEPTH];
  logic [GAIN_BITS-1:0] gain_r;
  stage_ctl_t           ctl_r;

  // Entry e: attenuation 120 dB * (D1 - e) / D1, last entry exactly 1.0.
  for (genvar e = 0; e < GAIN_TABLE_DEPTH; e++) begin : g_rom
    localparam logic [63:0] ATTEN = (ATTEN_FULL_Q24 * (D1 - 64'(e)) + D1 / 64'd2) / D1;
    localparam logic [GAIN_BITS-1:0] GAIN = gain_from_atten(ATTEN, ROOTS);
    assign rom_w[e] = GAIN;
  end

  always_ff @(posedge clk) begin
    gain_r <= rom_w[idx_i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  assign gain_o = gain_r;
  assign ctl_o  = ctl_r;

endmodule

`default_nettype wire

// ----- hdl/sdgf_level.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sdgf_level
  import sdgf_pkg::*;
#(
  parameter int GAIN_TABLE_DEPTH = 4096
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire cfg_wr_t                              cfg_i,
  input  wire logic                                 take_i,
  input  wire logic                                 last_i,
  output logic [$clog2(GAIN_TABLE_DEPTH)-1:0]       idx_o,
  output stage_ctl_t                                ctl_o
);

  localparam int IDX_W  = $clog2(GAIN_TABLE_DEPTH);
  localparam int PROD_W = SPAN_BITS + IDX_W + 1;
  localparam int Y_W    = PROD_W - SPAN_SHIFT;
  localparam int Q_W    = Y_W + RECIP_BITS;
  localparam int QS_W   = Q_W - RECIP_SHIFT;
  localparam logic [IDX_W-1:0] D1 = IDX_W'(GAIN_TABLE_DEPTH - 1);
  localparam logic signed [SUM_BITS-1:0]   SUM_MIN = SUM_BITS'(LEVEL_MIN_INT);
  localparam logic signed [LEVEL_BITS-1:0] LVL_MIN = LEVEL_BITS'(LEVEL_MIN_INT);

  logic                          fade_r;
  logic [STEP_BITS-1:0]          step_r;
  logic signed [LEVEL_BITS-1:0]  level_r;
  logic [SPAN_BITS-1:0]          u1_r;
  logic [Y_W-1:0]                y2_r;
  logic [IDX_W-1:0]              idx3_r;
  stage_ctl_t                    ctl1_r;
  stage_ctl_t                    ctl2_r;
  stage_ctl_t                    ctl3_r;

  logic signed [SUM_BITS-1:0]    lvl_ext;
  logic signed [SUM_BITS-1:0]    step_ext;
  logic signed [SUM_BITS-1:0]    sum;
  logic signed [SUM_BITS-1:0]    sum_clamp;
  logic signed [LEVEL_BITS-1:0]  level_nxt;
  logic [SPAN_BITS-1:0]          u1_nxt;
  logic signed [LEVEL_BITS-1:0]  cfg_lvl;
  logic signed [LEVEL_BITS-1:0]  start_lvl;
  logic [PROD_W-1:0]             prod;
  logic [Y_W-1:0]                y2_nxt;
  logic [Q_W-1:0]                q;
  logic [QS_W-1:0]               qs;
  logic [IDX_W-1:0]              idx3_nxt;

  // Level ramp and clamp, the only loop-carried path.
  always_comb begin
    lvl_ext  = {{(SUM_BITS-LEVEL_BITS){level_r[LEVEL_BITS-1]}}, level_r};
    step_ext = {{(SUM_BITS-STEP_BITS){1'b0}}, step_r};
    sum      = fade_r ? (lvl_ext - step_ext) : (lvl_ext + step_ext);
    if (sum > 26'sd0) begin
      sum_clamp = '0;
    end else if (sum < SUM_MIN) begin
      sum_clamp = SUM_MIN;
    end else begin
      sum_clamp = sum;
    end
    level_nxt = sum_clamp[LEVEL_BITS-1:0];
    u1_nxt    = SPAN_BITS'(sum_clamp + SUM_BITS'(LEVEL_SPAN));
  end

  always_comb begin
    cfg_lvl = cfg_i.data;
    if (cfg_lvl > 24'sd0) begin
      start_lvl = '0;
    end else if (cfg_lvl < LVL_MIN) begin
      start_lvl = LVL_MIN;
    end else begin
      start_lvl = cfg_lvl;
    end
  end

  // idx = round(u * D1 / span): shift by the power-of-two part, then divide by 15.
  always_comb begin
    prod     = PROD_W'(u1_r) * PROD_W'(D1) + PROD_W'(HALF_SPAN);
    y2_nxt   = prod[PROD_W-1:SPAN_SHIFT];
    q        = Q_W'(y2_r) * Q_W'(RECIP_15);
    qs       = q[Q_W-1:RECIP_SHIFT];
    idx3_nxt = (qs > QS_W'(D1)) ? D1 : qs[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_r  <= 1'b0;
      step_r  <= STEP_RESET;
      level_r <= '0;
      ctl1_r  <= '0;
      ctl2_r  <= '0;
      ctl3_r  <= '0;
    end else begin
      ctl1_r <= '{valid: take_i, last: last_i};
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      if (cfg_i.we) begin
        unique case (cfg_i.idx)
          REG_FADE_DOWN:   fade_r  <= cfg_i.data[0];
          REG_START_LEVEL: level_r <= start_lvl;
          REG_STEP_SIZE:   step_r  <= cfg_i.data[STEP_BITS-1:0];
          default: ;
        endcase
      end else if (take_i) begin
        level_r <= level_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    u1_r   <= u1_nxt;
    y2_r   <= y2_nxt;
    idx3_r <= idx3_nxt;
  end

  assign idx_o = idx3_r;
  assign ctl_o = ctl3_r;

endmodule

`default_nettype wire

// ----- hdl/sdgf_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sdgf_lane
  import sdgf_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  input  wire logic [GAIN_BITS-1:0]          gain_i,
  output logic signed [SAMPLE_BITS-1:0]      result_o
);

  logic signed [SAMPLE_BITS-1:0]           dly_r [SAMPLE_DELAY];
  logic signed [SAMPLE_BITS-1:0]           result_r;
  logic signed [SAMPLE_BITS+GAIN_BITS:0]   prod;

  // Arithmetic shift: rounds toward minus infinity.
  always_comb begin
    prod = dly_r[SAMPLE_DELAY-1] * $signed({1'b0, gain_i});
  end

  always_ff @(posedge clk) begin
    dly_r[0] <= sample_i;
    for (int i = 1; i < SAMPLE_DELAY; i++) begin
      dly_r[i] <= dly_r[i-1];
    end
    result_r <= prod[GAIN_FRAC+SAMPLE_BITS-1:GAIN_FRAC];
  end

  assign result_o = result_r;

endmodule

`default_nettype wire

// ----- hdl/sdgf_merge.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sdgf_merge
  import sdgf_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          take_i,
  input  wire stage_ctl_t                    ctl_i,
  input  wire logic signed [SAMPLE_BITS-1:0] left_i,
  input  wire logic signed [SAMPLE_BITS-1:0] right_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output out_item_t                          out_data_o,
  output logic                               credit_o
);

  localparam int QP_W = $clog2(QUEUE_DEPTH);

  stage_ctl_t        ctl5_r;
  out_item_t         queue_r [QUEUE_DEPTH];
  logic [QP_W-1:0]   wr_ptr_r;
  logic [QP_W-1:0]   rd_ptr_r;
  logic [QP_W:0]     cnt_r;
  logic [QP_W:0]     occ_r;
  logic              push;
  logic              pop;

  assign push = ctl5_r.valid;
  assign pop  = out_valid_o && out_ready_i;

  // occ_r counts pairs from input transfer to output transfer, so the
  // queue can never overflow.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl5_r   <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      occ_r    <= '0;
    end else begin
      ctl5_r <= ctl_i;
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + (QP_W+1)'(push) - (QP_W+1)'(pop);
      occ_r <= occ_r + (QP_W+1)'(take_i) - (QP_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= '{left_out: left_i, right_out: right_i, last: ctl5_r.last};
    end
  end

  assign out_valid_o = (cnt_r != '0);
  assign out_data_o  = queue_r[rd_ptr_r];
  assign credit_o    = (occ_r < (QP_W+1)'(QUEUE_DEPTH));

endmodule

`default_nettype wire

// ----- hdl/stereo_db_gain_fade_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel  Ports                           Dir  Item
// in       in_valid  in_ready  in_data     in   one stereo sample pair
// out      out_valid out_ready out_data    out  gain-scaled pair and last flag
// cfg      cfg_we    cfg_idx   cfg_wdata   in   register write, no wait
//
// One pair per cycle unless out stalls; out_valid follows level, ROM, lane and queue registers.
// Only the level ramp register is loop-carried; index math, ROM read and multiplies pipeline.
// Up to 8 pairs in flight: the output queue credit count sets when in_ready drops.
// Synchronous reset sets 0 dB, fade up, default step and empties the queue; ROM is constant.
// Out stalls fill the queue, then in_ready drops; no combinational path from out_ready.

module stereo_db_gain_fade_top
  import sdgf_pkg::*;
#(
  parameter int GAIN_TABLE_DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire in_item_t                 in_data,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output out_item_t                     out_data,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(GAIN_TABLE_DEPTH);

  logic                          take;
  logic                          credit;
  cfg_wr_t                       cfg_wr;
  logic [IDX_W-1:0]              idx;
  stage_ctl_t                    ctl_idx;
  stage_ctl_t                    ctl_gain;
  logic [GAIN_BITS-1:0]          gain;
  logic signed [SAMPLE_BITS-1:0] left_res;
  logic signed [SAMPLE_BITS-1:0] right_res;

  assign in_ready = credit;
  assign take     = in_valid && in_ready;
  assign cfg_wr   = '{we: cfg_we, idx: cfg_idx, data: cfg_wdata};

  sdgf_level #(
    .GAIN_TABLE_DEPTH(GAIN_TABLE_DEPTH)
  ) u_level (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_i  (cfg_wr),
    .take_i (take),
    .last_i (in_data.end_of_buffer),
    .idx_o  (idx),
    .ctl_o  (ctl_idx)
  );

  sdgf_gain_rom #(
    .GAIN_TABLE_DEPTH(GAIN_TABLE_DEPTH)
  ) u_rom (
    .clk    (clk),
    .rst_n  (rst_n),
    .idx_i  (idx),
    .ctl_i  (ctl_idx),
    .gain_o (gain),
    .ctl_o  (ctl_gain)
  );

  sdgf_lane u_lane_left (
    .clk      (clk),
    .sample_i (in_data.left_in),
    .gain_i   (gain),
    .result_o (left_res)
  );

  sdgf_lane u_lane_right (
    .clk      (clk),
    .sample_i (in_data.right_in),
    .gain_i   (gain),
    .result_o (right_res)
  );

  sdgf_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .take_i      (take),
    .ctl_i       (ctl_gain),
    .left_i      (left_res),
    .right_i     (right_res),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .credit_o    (credit)
  );

endmodule

`default_nettype wire

// ----- hdl/sdgf_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "stereo_db_gain_fade_top_macros.svh"

module sdgf_checker
  import sdgf_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  `SDGF_ASSERT_RST(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "out transfer dropped or changed while stalled")
  `SDGF_ASSERT_RST(a_in_hold, in_valid && !in_ready |=> in_valid && $stable(in_data), "in transfer withdrawn or changed while stalled")
  // Credit only shrinks on an input transfer.
  `SDGF_ASSERT_RST(a_ready_keep, in_ready && !in_valid |=> in_ready, "in_ready dropped without an input transfer")
  `SDGF_ASSERT_CLK(a_reset_empty, !rst_n |=> !out_valid, "result shown right after reset")

endmodule

bind stereo_db_gain_fade_top sdgf_checker u_sdgf_checker (.*);

`default_nettype wire
